### src/trigger_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Trigger frame deframer assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_FRAME_DEFRAMER_MACROS_SVH
`define TRIGGER_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define TFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the trigger frame deframer modules.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int PADDING_COUNT_MAX_DEF = 4095;
  localparam int PAD_OUT_MAX           = 4095;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register index (paddr[2])
  localparam logic REG_PARSE_USER_INFO = 1'b0;

  // record kinds
  localparam logic [1:0] KIND_COMMON  = 2'd0;
  localparam logic [1:0] KIND_USER    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_AID_4095  = 2'd1;
  localparam logic [1:0] ERR_AID_RANGE = 2'd2;
  localparam logic [1:0] ERR_TRUNC     = 2'd3;

  localparam logic [11:0] AID_RESERVED = 12'hFFF;
  localparam logic [11:0] AID_FIRST_BAD = 12'd2045;

  typedef enum logic [1:0] {
    PH_COMMON = 2'd0,
    PH_USER   = 2'd1,
    PH_PAD    = 2'd2,
    PH_SKIP   = 2'd3
  } tfd_phase_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  type_or_ru;
    logic [11:0] length_or_aid;
    logic [1:0]  common_flags;
    logic [1:0]  ul_bandwidth_code;
    logic [1:0]  txs_mode_code;
    logic [8:0]  power_or_duration;
    logic [15:0] spatial_reuse;
    logic        variant_or_ps160;
    logic [11:0] padding_bytes;
    logic [1:0]  error_code;
    logic        last_result;
  } tfd_result_t;

  // results from one accepted byte, first is delivered first
  typedef struct packed {
    logic [1:0]  num;
    tfd_result_t first;
    tfd_result_t second;
  } tfd_parse_out_t;

  typedef struct packed {
    logic room2;
  } tfd_fifo_status_t;

endpackage

### src/tfd_parser.sv
// ----------------------------------------------------------------------------
// tfd_parser
// Frame state and field extraction: one byte in, up to two results out.
// ----------------------------------------------------------------------------
module tfd_parser #(
  parameter int PAD_CNT_MAX = tfd_pkg::PADDING_COUNT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   frame_last,
  input  logic                   parse_user_info,
  output tfd_pkg::tfd_parse_out_t parse_o
);

  localparam int CNT_W = $clog2(PAD_CNT_MAX + 1);
  localparam int EXT_W = (CNT_W > 12) ? CNT_W : 12;

  tfd_pkg::tfd_phase_t phase_r, phase_nxt;
  logic [2:0]          pos_r, pos_nxt;
  logic [63:0]         asm_r, asm_nxt;
  logic                he_r, he_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [63:0]      w;
  logic             common_done, pad_start, user_done, trunc, he_new;
  logic [CNT_W-1:0] cnt_after;
  logic [EXT_W-1:0] cnt_ext;
  logic [11:0]      pad_out;
  tfd_pkg::tfd_result_t rec, summ;

  assign w = asm_r | ({56'd0, data_byte} << {pos_r, 3'b000});

  assign common_done = (phase_r == tfd_pkg::PH_COMMON) && (pos_r == 3'd7);
  assign pad_start   = (phase_r == tfd_pkg::PH_USER) && (pos_r == 3'd1) &&
                       (w[15:0] == 16'hFFFF);
  assign user_done   = (phase_r == tfd_pkg::PH_USER) && !pad_start && (pos_r >= 3'd4);
  assign trunc       = frame_last &&
                       (((phase_r == tfd_pkg::PH_COMMON) && (pos_r != 3'd7)) ||
                        ((phase_r == tfd_pkg::PH_USER) && !pad_start &&
                         (pos_r >= 3'd1) && (pos_r < 3'd4)));
  assign he_new      = (w[55:54] == 2'b11);

  // padding count as seen after this byte
  always_comb begin
    cnt_after = cnt_r;
    if (pad_start) begin
      cnt_after = CNT_W'(2);
    end else if ((phase_r == tfd_pkg::PH_PAD) && (cnt_r < CNT_W'(PAD_CNT_MAX))) begin
      cnt_after = cnt_r + CNT_W'(1);
    end
  end

  assign cnt_ext = EXT_W'(cnt_after);
  assign pad_out = (cnt_ext > EXT_W'(tfd_pkg::PAD_OUT_MAX)) ? 12'hFFF : cnt_ext[11:0];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    asm_nxt   = asm_r;
    he_nxt    = he_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      unique case (phase_r)
        tfd_pkg::PH_COMMON: begin
          if (common_done) begin
            he_nxt    = he_new;
            phase_nxt = parse_user_info ? tfd_pkg::PH_USER : tfd_pkg::PH_SKIP;
            pos_nxt   = 3'd0;
            asm_nxt   = 64'd0;
          end else begin
            pos_nxt = pos_r + 3'd1;
            asm_nxt = w;
          end
        end
        tfd_pkg::PH_USER: begin
          if (pad_start) begin
            phase_nxt = tfd_pkg::PH_PAD;
            cnt_nxt   = cnt_after;
            pos_nxt   = 3'd0;
            asm_nxt   = 64'd0;
          end else if (user_done) begin
            pos_nxt = 3'd0;
            asm_nxt = 64'd0;
          end else begin
            pos_nxt = pos_r + 3'd1;
            asm_nxt = w;
          end
        end
        tfd_pkg::PH_PAD: cnt_nxt = cnt_after;
        tfd_pkg::PH_SKIP: ;
        default: ;
      endcase
      if (frame_last) begin
        phase_nxt = tfd_pkg::PH_COMMON;
        pos_nxt   = 3'd0;
        asm_nxt   = 64'd0;
        cnt_nxt   = '0;
      end
    end
  end

  // results
  always_comb begin
    rec  = '0;
    summ = '0;
    if (common_done) begin
      rec.record_kind       = tfd_pkg::KIND_COMMON;
      rec.type_or_ru        = {4'd0, w[3:0]};
      rec.length_or_aid     = w[15:4];
      rec.common_flags      = w[17:16];
      rec.ul_bandwidth_code = w[19:18];
      rec.txs_mode_code     = w[21:20];
      rec.power_or_duration = {3'd0, w[33:28]};
      rec.spatial_reuse     = w[52:37];
      rec.variant_or_ps160  = he_new;
    end else begin
      rec.record_kind       = tfd_pkg::KIND_USER;
      rec.type_or_ru        = w[19:12];
      rec.length_or_aid     = w[11:0];
      rec.power_or_duration = w[28:20];
      rec.variant_or_ps160  = he_r ? 1'b0 : w[39];
      if (w[11:0] == tfd_pkg::AID_RESERVED) begin
        rec.error_code = tfd_pkg::ERR_AID_4095;
      end else if ((w[11:0] == 12'd0) || (w[11:0] >= tfd_pkg::AID_FIRST_BAD)) begin
        rec.error_code = tfd_pkg::ERR_AID_RANGE;
      end
    end
    rec.last_result = !frame_last;

    summ.record_kind   = tfd_pkg::KIND_SUMMARY;
    summ.padding_bytes = pad_out;
    summ.error_code    = trunc ? tfd_pkg::ERR_TRUNC : tfd_pkg::ERR_OK;
    summ.last_result   = 1'b1;

    parse_o.num    = accept ? (2'((common_done || user_done)) + 2'(frame_last)) : 2'd0;
    parse_o.first  = (common_done || user_done) ? rec : summ;
    parse_o.second = summ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfd_pkg::PH_COMMON;
      pos_r   <= 3'd0;
      asm_r   <= 64'd0;
      he_r    <= 1'b1;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      asm_r   <= asm_nxt;
      he_r    <= he_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### src/tfd_out_fifo.sv
// ----------------------------------------------------------------------------
// tfd_out_fifo
// Result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module tfd_out_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tfd_pkg::tfd_parse_out_t  push,
  output tfd_pkg::tfd_result_t     head,
  output logic                     head_valid,
  input  logic                     head_ready,
  output tfd_pkg::tfd_fifo_status_t status
);

  localparam int PW = tfd_pkg::FIFO_PTR_W;
  localparam int CW = tfd_pkg::FIFO_CNT_W;

  tfd_pkg::tfd_result_t mem_r [tfd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign head_valid   = (cnt_r != '0);
  assign head         = mem_r[rd_ptr_r];
  assign pop          = head_valid && head_ready;
  assign status.room2 = (cnt_r <= CW'(tfd_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.num);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push.num) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/trigger_frame_deframer.sv
// A byte's results are registered in the result queue and appear on out_* from its head.
// Throughput: one byte per cycle while in_tready is high; the queue drains one result
// per cycle while out_tready is high; a byte with a record and a summary yields two results.
// in_tready stays high while the four-entry queue has two free slots.
// Reset: synchronous, active low; clears frame state, queue and sets
// parse_user_info to 1.
// ----------------------------------------------------------------------------
// trigger_frame_deframer
// Trigger frame body parser: common info, user info records, padding, summary.
// ----------------------------------------------------------------------------
`include "trigger_frame_deframer_macros.svh"

module trigger_frame_deframer #(
  parameter int PADDING_COUNT_MAX = tfd_pkg::PADDING_COUNT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_last
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] type_or_ru, [19:8] length_or_aid, [21:20] common_flags,
  // [23:22] ul_bandwidth_code, [25:24] txs_mode_code, [34:26] power_or_duration,
  // [50:35] spatial_reuse, [51] variant_or_ps160, [63:52] padding_bytes,
  // [65:64] error_code, [71:66] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast,  // last_result
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                      parse_user_info_r, parse_user_info_nxt;
  logic                      in_accept;
  tfd_pkg::tfd_parse_out_t   parse_o;
  tfd_pkg::tfd_result_t      head;
  tfd_pkg::tfd_fifo_status_t fifo_st;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tfd_pkg::REG_PARSE_USER_INFO) ?
                      {31'd0, parse_user_info_r} : 32'd0;

  always_comb begin
    parse_user_info_nxt = parse_user_info_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        (cfg_paddr[2] == tfd_pkg::REG_PARSE_USER_INFO)) begin
      parse_user_info_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_user_info_r <= 1'b1;
    end else begin
      parse_user_info_r <= parse_user_info_nxt;
    end
  end

  assign in_tready = fifo_st.room2;
  assign in_accept = in_tvalid && in_tready;

  tfd_parser #(
    .PAD_CNT_MAX (PADDING_COUNT_MAX)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .data_byte       (in_tdata),
    .frame_last      (in_tlast),
    .parse_user_info (parse_user_info_r),
    .parse_o         (parse_o)
  );

  tfd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (parse_o),
    .head       (head),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .status     (fifo_st)
  );

  assign out_tuser = head.record_kind;
  assign out_tlast = head.last_result;
  assign out_tdata = {6'd0, head.error_code, head.padding_bytes, head.variant_or_ps160,
                      head.spatial_reuse, head.power_or_duration, head.txs_mode_code,
                      head.ul_bandwidth_code, head.common_flags, head.length_or_aid,
                      head.type_or_ru};

  // a frame end always leaves a summary waiting
  `TFD_ASSERT_NEXT(a_frame_end_result, clk, rst_n, in_accept && in_tlast, out_tvalid, "frame end gave no result")
  // summary is always the last result of its byte
  `TFD_ASSERT_NOW(a_summary_last, clk, rst_n, out_tvalid && (out_tuser == tfd_pkg::KIND_SUMMARY), out_tlast, "summary without last")
  // a byte with two results puts a record ahead of the summary
  `TFD_ASSERT_NOW(a_pair_order, clk, rst_n, parse_o.num == 2'd2, (parse_o.first.record_kind != tfd_pkg::KIND_SUMMARY) && !parse_o.first.last_result && in_tlast, "bad result pair")

endmodule
